// ===== rtl/sparse_weighted_overlap_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_WEIGHTED_OVERLAP_DEFINES_SVH
`define SPARSE_WEIGHTED_OVERLAP_DEFINES_SVH

// same-cycle implication
`define SWO_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWO_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/swo_pkg.sv =====
// ----------------------------------------------------------------------------
// swo_pkg
// Types, widths and helpers shared by the weighted overlap datapath.
// ----------------------------------------------------------------------------
package swo_pkg;

    localparam int TERM_SLOTS_DEF = 64;
    localparam int HASH_W        = 64;
    localparam int WEIGHT_W      = 24;
    localparam int SUM_W         = 30;
    localparam int QUO_W         = 16;
    localparam int RATIO_W       = QUO_W + 1;

    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [RATIO_W-1:0] RATIO_ONE = {1'b1, {QUO_W{1'b0}}};

    typedef struct packed {
        logic                valid;
        logic [HASH_W-1:0]   hash;
        logic [WEIGHT_W-1:0] weight;
    } term_t;

    typedef struct packed {
        logic clear;
        logic pop;
        logic load;
    } chain_ctrl_t;

    function automatic logic [SUM_W-1:0] sat_add(
        input logic [SUM_W-1:0]    acc,
        input logic [WEIGHT_W-1:0] w
    );
        logic [SUM_W:0] s;
        s = {1'b0, acc} + {{(SUM_W + 1 - WEIGHT_W){1'b0}}, w};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    function automatic logic [WEIGHT_W-1:0] min_weight(
        input logic [WEIGHT_W-1:0] a,
        input logic [WEIGHT_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

// ===== rtl/swo_cell.sv =====
// ----------------------------------------------------------------------------
// swo_cell
// One slot of the stored-term chain: loads when it is the first free slot,
// takes its right neighbor's term on a pop, empties on a clear.
// ----------------------------------------------------------------------------
module swo_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  swo_pkg::chain_ctrl_t ctrl,
    input  swo_pkg::term_t      load_term,
    input  logic                left_valid,
    input  swo_pkg::term_t      right_term,
    output swo_pkg::term_t      term
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [swo_pkg::HASH_W-1:0]     hash_reg;
    logic [swo_pkg::HASH_W-1:0]     hash_next;
    logic [swo_pkg::WEIGHT_W-1:0]   weight_reg;
    logic [swo_pkg::WEIGHT_W-1:0]   weight_next;
    logic                           take_load;

    assign take_load = ctrl.load && !valid_reg && left_valid;

    always_comb
    begin
        valid_next  = valid_reg;
        hash_next   = hash_reg;
        weight_next = weight_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.pop)
        begin
            valid_next  = right_term.valid;
            hash_next   = right_term.hash;
            weight_next = right_term.weight;
        end
        else if (take_load)
        begin
            valid_next  = load_term.valid;
            hash_next   = load_term.hash;
            weight_next = load_term.weight;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg   <= hash_next;
        weight_reg <= weight_next;
    end

    assign term.valid  = valid_reg;
    assign term.hash   = hash_reg;
    assign term.weight = weight_reg;

endmodule

// ===== rtl/swo_divider.sv =====
// ----------------------------------------------------------------------------
// swo_divider
// Restoring divider, one quotient bit per cycle, for a dividend below the
// divisor: quotient = floor(dividend * 2^QUO_W / divisor).
// ----------------------------------------------------------------------------
module swo_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [swo_pkg::SUM_W-1:0]   dividend,
    input  logic [swo_pkg::SUM_W-1:0]   divisor,
    output logic                        done,
    output logic [swo_pkg::QUO_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(swo_pkg::QUO_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(swo_pkg::QUO_W - 1);

    logic                         busy_reg;
    logic                         busy_next;
    logic                         done_reg;
    logic                         done_next;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic [swo_pkg::SUM_W-1:0]    rem_reg;
    logic [swo_pkg::SUM_W-1:0]    rem_next;
    logic [swo_pkg::SUM_W-1:0]    div_reg;
    logic [swo_pkg::SUM_W-1:0]    div_next;
    logic [swo_pkg::QUO_W-1:0]    quo_reg;
    logic [swo_pkg::QUO_W-1:0]    quo_next;
    logic [swo_pkg::SUM_W:0]      shifted;
    logic [swo_pkg::SUM_W:0]      diff;
    logic                         fits;

    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, div_reg};
    assign fits    = shifted >= {1'b0, div_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            rem_next   = dividend;
            div_next   = divisor;
            quo_next   = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = fits ? diff[swo_pkg::SUM_W-1:0] : shifted[swo_pkg::SUM_W-1:0];
            quo_next   = {quo_reg[swo_pkg::QUO_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/sparse_weighted_overlap.sv =====
// Flow: an A term is loaded into the chain directly; a B term is registered, then
// merged, skipping stored terms (head compare in the first cell, one per cycle).
// Final B item: merge, finish, divider (unless empty or one), output register.
// Throughput: one item at a time; the result register frees the input side.
// Reset: asynchronous, active low; clears the chain, counts, sums and output.
// ----------------------------------------------------------------------------
// sparse_weighted_overlap
// Weighted overlap coefficient of two sorted sparse signatures: stores the
// first list in a shifting chain of cells and merge-joins the second against
// its head, then divides the intersection by the smaller weight sum.
// ----------------------------------------------------------------------------
`include "sparse_weighted_overlap_defines.svh"

module sparse_weighted_overlap #(
    parameter int TERM_SLOTS = swo_pkg::TERM_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            list_select,
    input  logic [swo_pkg::HASH_W-1:0]      term_hash,
    input  logic [swo_pkg::WEIGHT_W-1:0]    term_weight,
    input  logic                            no_term,
    input  logic                            list_end,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [swo_pkg::RATIO_W-1:0]     overlap_ratio,
    output logic [swo_pkg::SUM_W-1:0]       intersection_weight,
    output logic [swo_pkg::SUM_W-1:0]       smaller_sum,
    output logic                            empty_signature
);

    localparam int CNT_W = $clog2(TERM_SLOTS + 1);
    localparam logic [CNT_W-1:0] CAPACITY = CNT_W'(TERM_SLOTS);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_MERGE  = 5'b00010,
        ST_FINISH = 5'b00100,
        ST_DIV    = 5'b01000,
        ST_HOLD   = 5'b10000
    } state_t;

    state_t                          state_reg;
    state_t                          state_next;
    logic [CNT_W-1:0]                first_count_reg;
    logic [CNT_W-1:0]                first_count_next;
    logic [CNT_W-1:0]                second_count_reg;
    logic [CNT_W-1:0]                second_count_next;
    logic [swo_pkg::SUM_W-1:0]       first_sum_reg;
    logic [swo_pkg::SUM_W-1:0]       first_sum_next;
    logic [swo_pkg::SUM_W-1:0]       second_sum_reg;
    logic [swo_pkg::SUM_W-1:0]       second_sum_next;
    logic [swo_pkg::SUM_W-1:0]       shared_sum_reg;
    logic [swo_pkg::SUM_W-1:0]       shared_sum_next;
    logic [swo_pkg::HASH_W-1:0]      b_hash_reg;
    logic [swo_pkg::HASH_W-1:0]      b_hash_next;
    logic [swo_pkg::WEIGHT_W-1:0]    b_weight_reg;
    logic [swo_pkg::WEIGHT_W-1:0]    b_weight_next;
    logic                            b_last_reg;
    logic                            b_last_next;
    logic [swo_pkg::SUM_W-1:0]       res_shared_reg;
    logic [swo_pkg::SUM_W-1:0]       res_shared_next;
    logic [swo_pkg::SUM_W-1:0]       res_smaller_reg;
    logic [swo_pkg::SUM_W-1:0]       res_smaller_next;
    logic                            res_empty_reg;
    logic                            res_empty_next;
    logic [swo_pkg::RATIO_W-1:0]     res_ratio_reg;
    logic [swo_pkg::RATIO_W-1:0]     res_ratio_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [swo_pkg::RATIO_W-1:0]     out_ratio_reg;
    logic [swo_pkg::SUM_W-1:0]       out_shared_reg;
    logic [swo_pkg::SUM_W-1:0]       out_smaller_reg;
    logic                            out_empty_reg;

    logic                            in_fire;
    logic                            out_load;
    logic                            div_start;
    logic                            div_done;
    logic [swo_pkg::QUO_W-1:0]       div_quotient;
    logic [swo_pkg::SUM_W-1:0]       smaller_now;
    logic                            empty_now;
    logic                            head_less;
    logic                            head_equal;
    swo_pkg::chain_ctrl_t            chain_ctrl;
    swo_pkg::term_t                  load_term;
    swo_pkg::term_t                  cell_term [TERM_SLOTS];
    swo_pkg::term_t                  head;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign head      = cell_term[0];
    assign head_less  = head.valid && (head.hash < b_hash_reg);
    assign head_equal = head.valid && (head.hash == b_hash_reg);
    assign smaller_now = (first_sum_reg < second_sum_reg) ? first_sum_reg : second_sum_reg;
    assign empty_now   = (first_sum_reg == '0) || (second_sum_reg == '0);

    assign load_term.valid  = 1'b1;
    assign load_term.hash   = term_hash;
    assign load_term.weight = term_weight;

    // stored-term chain, head in cell 0
    for (genvar i = 0; i < TERM_SLOTS; i++)
    begin : g_chain
        logic           left_valid;
        swo_pkg::term_t right_term;

        if (i == 0)
        begin : g_head
            assign left_valid = 1'b1;
        end
        else
        begin : g_body
            assign left_valid = cell_term[i-1].valid;
        end

        if (i == TERM_SLOTS - 1)
        begin : g_tail
            assign right_term = '0;
        end
        else
        begin : g_link
            assign right_term = cell_term[i+1];
        end

        swo_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (chain_ctrl),
            .load_term  (load_term),
            .left_valid (left_valid),
            .right_term (right_term),
            .term       (cell_term[i])
        );
    end

    swo_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (shared_sum_reg),
        .divisor  (smaller_now),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        first_sum_next    = first_sum_reg;
        second_sum_next   = second_sum_reg;
        shared_sum_next   = shared_sum_reg;
        b_hash_next       = b_hash_reg;
        b_weight_next     = b_weight_reg;
        b_last_next       = b_last_reg;
        res_shared_next   = res_shared_reg;
        res_smaller_next  = res_smaller_reg;
        res_empty_next    = res_empty_reg;
        res_ratio_next    = res_ratio_reg;
        chain_ctrl        = '0;
        div_start         = 1'b0;
        out_load          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (!list_select)
                    begin
                        if (!no_term && (first_count_reg < CAPACITY))
                        begin
                            chain_ctrl.load  = 1'b1;
                            first_count_next = first_count_reg + 1'b1;
                            first_sum_next   = swo_pkg::sat_add(first_sum_reg, term_weight);
                        end
                    end
                    else if (!no_term && (second_count_reg < CAPACITY))
                    begin
                        second_count_next = second_count_reg + 1'b1;
                        second_sum_next   = swo_pkg::sat_add(second_sum_reg, term_weight);
                        b_hash_next       = term_hash;
                        b_weight_next     = term_weight;
                        b_last_next       = list_end;
                        state_next        = ST_MERGE;
                    end
                    else if (list_end)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_MERGE:
            begin
                chain_ctrl.pop = head_less || head_equal;
                if (head_equal)
                begin
                    shared_sum_next = swo_pkg::sat_add(shared_sum_reg,
                        swo_pkg::min_weight(head.weight, b_weight_reg));
                end
                if (!head_less)
                begin
                    state_next = b_last_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                res_shared_next  = shared_sum_reg;
                res_smaller_next = smaller_now;
                res_empty_next   = empty_now;
                if (empty_now)
                begin
                    res_ratio_next = '0;
                    state_next     = ST_HOLD;
                end
                else if (shared_sum_reg >= smaller_now)
                begin
                    res_ratio_next = swo_pkg::RATIO_ONE;
                    state_next     = ST_HOLD;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                // drop the run for the next pair
                chain_ctrl.clear  = 1'b1;
                first_count_next  = '0;
                second_count_next = '0;
                first_sum_next    = '0;
                second_sum_next   = '0;
                shared_sum_next   = '0;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_ratio_next = {1'b0, div_quotient};
                    state_next     = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            first_sum_reg    <= '0;
            second_sum_reg   <= '0;
            shared_sum_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            first_sum_reg    <= first_sum_next;
            second_sum_reg   <= second_sum_next;
            shared_sum_reg   <= shared_sum_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        b_hash_reg      <= b_hash_next;
        b_weight_reg    <= b_weight_next;
        b_last_reg      <= b_last_next;
        res_shared_reg  <= res_shared_next;
        res_smaller_reg <= res_smaller_next;
        res_empty_reg   <= res_empty_next;
        res_ratio_reg   <= res_ratio_next;
        if (out_load)
        begin
            out_ratio_reg   <= res_ratio_reg;
            out_shared_reg  <= res_shared_reg;
            out_smaller_reg <= res_smaller_reg;
            out_empty_reg   <= res_empty_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign overlap_ratio       = out_ratio_reg;
    assign intersection_weight = out_shared_reg;
    assign smaller_sum         = out_smaller_reg;
    assign empty_signature     = out_empty_reg;

    `SWO_ASSERT_IMP(a_div_done_in_div, div_done, state_reg == ST_DIV,
        "divider finished outside the divide state")
    `SWO_ASSERT_NXT(a_finish_clears, state_reg == ST_FINISH,
        first_count_reg == '0 && second_count_reg == '0 && shared_sum_reg == '0
        && !cell_term[0].valid, "run state not cleared after finish")
    `SWO_ASSERT_IMP(a_pop_needs_head, chain_ctrl.pop, head.valid && state_reg == ST_MERGE,
        "chain popped without a stored head term")
    `SWO_ASSERT_IMP(a_empty_zero_ratio, out_valid_reg && out_empty_reg,
        out_ratio_reg == '0, "empty signature with nonzero ratio")

endmodule

// ===== test/sparse_weighted_overlap_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_weighted_overlap_tb
// Streams pairs of sparse signatures into the overlap block and scores each
// pair with an independent merge-join predictor. A short table covers the
// field extremes, empty signatures, truncation and out-of-order input. Random
// pairs follow, mostly sorted lists with shared hashes, some past capacity,
// and some with broken order, interleaved lists or filler transactions. Both
// sides idle at random, and one long output hold backs up the block.
// ----------------------------------------------------------------------------
module sparse_weighted_overlap_tb;

    localparam int TERM_CAP     = swo_pkg::TERM_SLOTS_DEF;
    localparam int TARGET_TERMS = 900;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 500000;

    localparam logic SEL_FIRST  = 1'b0;
    localparam logic SEL_SECOND = 1'b1;

    typedef struct packed {
        logic [swo_pkg::RATIO_W-1:0] ratio;
        logic [swo_pkg::SUM_W-1:0]   shared;
        logic [swo_pkg::SUM_W-1:0]   smaller;
        logic                        empty;
    } overlap_score_t;

    typedef struct packed {
        logic                         sel;
        logic [swo_pkg::HASH_W-1:0]   hash;
        logic [swo_pkg::WEIGHT_W-1:0] weight;
        logic                         nt;
        logic                         le;
        bit                           typed;
        overlap_score_t               score;
    } stim_row_t;

    logic                         clk;
    logic                         rst_n       = 1'b0;
    logic                         in_valid    = 1'b0;
    logic                         in_stall;
    logic                         list_select = 1'b0;
    logic [swo_pkg::HASH_W-1:0]   term_hash   = '0;
    logic [swo_pkg::WEIGHT_W-1:0] term_weight = '0;
    logic                         no_term     = 1'b0;
    logic                         list_end    = 1'b0;
    logic                         out_valid;
    logic                         out_stall   = 1'b0;
    logic [swo_pkg::RATIO_W-1:0]  overlap_ratio;
    logic [swo_pkg::SUM_W-1:0]    intersection_weight;
    logic [swo_pkg::SUM_W-1:0]    smaller_sum;
    logic                         empty_signature;

    logic [swo_pkg::HASH_W-1:0]   stored_hash [TERM_CAP];
    logic [swo_pkg::WEIGHT_W-1:0] stored_weight [TERM_CAP];
    int                           stored_count;
    int                           merge_pos;
    int                           second_taken;
    logic [swo_pkg::SUM_W-1:0]    sum_first;
    logic [swo_pkg::SUM_W-1:0]    sum_second;
    logic [swo_pkg::SUM_W-1:0]    shared_weight;

    overlap_score_t      pending_scores[$];
    stim_row_t           directed_rows[$];

    int  failures      = 0;
    int  accepted      = 0;
    int  scores_seen   = 0;
    int  empty_scores  = 0;
    int  dropped_terms = 0;
    int  random_terms  = 0;
    int  cycles        = 0;
    bit  no_idle       = 1'b0;
    bit  hold_request  = 1'b0;

    sparse_weighted_overlap DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .list_select         (list_select),
        .term_hash           (term_hash),
        .term_weight         (term_weight),
        .no_term             (no_term),
        .list_end            (list_end),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .overlap_ratio       (overlap_ratio),
        .intersection_weight (intersection_weight),
        .smaller_sum         (smaller_sum),
        .empty_signature     (empty_signature)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [swo_pkg::SUM_W-1:0] capped_sum(
        input logic [swo_pkg::SUM_W-1:0]    acc,
        input logic [swo_pkg::WEIGHT_W-1:0] w
    );
        logic [swo_pkg::SUM_W:0] total;
        total = {1'b0, acc} + {{(swo_pkg::SUM_W + 1 - swo_pkg::WEIGHT_W){1'b0}}, w};
        if (total > {1'b0, swo_pkg::SUM_MAX})
            total = {1'b0, swo_pkg::SUM_MAX};
        return total[swo_pkg::SUM_W-1:0];
    endfunction

    function automatic stim_row_t make_row(
        input logic                         sel,
        input logic [swo_pkg::HASH_W-1:0]   hash,
        input logic [swo_pkg::WEIGHT_W-1:0] weight,
        input logic                         nt,
        input logic                         le
    );
        stim_row_t row;
        row        = '0;
        row.sel    = sel;
        row.hash   = hash;
        row.weight = weight;
        row.nt     = nt;
        row.le     = le;
        return row;
    endfunction

    function automatic stim_row_t with_score(
        input stim_row_t                   row,
        input logic [swo_pkg::RATIO_W-1:0] ratio,
        input logic [swo_pkg::SUM_W-1:0]   shared,
        input logic [swo_pkg::SUM_W-1:0]   smaller,
        input logic                        empty
    );
        row.typed         = 1'b1;
        row.score.ratio   = ratio;
        row.score.shared  = shared;
        row.score.smaller = smaller;
        row.score.empty   = empty;
        return row;
    endfunction

    function automatic logic [swo_pkg::WEIGHT_W-1:0] pick_weight();
        int          roll;
        int unsigned raw;
        roll = $urandom_range(19);
        raw  = $urandom_range(0, 32'h00FF_FFFF);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return raw[swo_pkg::WEIGHT_W-1:0];
    endfunction

    task automatic score_transaction(
        input  stim_row_t      t,
        output bit             produced,
        output overlap_score_t s
    );
        logic [63:0]                  quotient;
        logic [swo_pkg::WEIGHT_W-1:0] lower;
        produced = 1'b0;
        s        = '0;
        if (t.sel == SEL_FIRST)
        begin
            if (!t.nt && stored_count < TERM_CAP)
            begin
                stored_hash[stored_count]   = t.hash;
                stored_weight[stored_count] = t.weight;
                stored_count++;
                sum_first = capped_sum(sum_first, t.weight);
            end
            else if (!t.nt)
                dropped_terms++;
        end
        else
        begin
            if (!t.nt && second_taken < TERM_CAP)
            begin
                second_taken++;
                sum_second = capped_sum(sum_second, t.weight);
                while (merge_pos < stored_count && stored_hash[merge_pos] < t.hash)
                    merge_pos++;
                if (merge_pos < stored_count && stored_hash[merge_pos] == t.hash)
                begin
                    lower = (stored_weight[merge_pos] < t.weight) ?
                            stored_weight[merge_pos] : t.weight;
                    shared_weight = capped_sum(shared_weight, lower);
                    merge_pos++;
                end
            end
            else if (!t.nt)
                dropped_terms++;
            if (t.le)
            begin
                produced  = 1'b1;
                s.shared  = shared_weight;
                s.smaller = (sum_first < sum_second) ? sum_first : sum_second;
                s.empty   = (sum_first == '0) || (sum_second == '0);
                if (!s.empty)
                begin
                    quotient = (64'(shared_weight) << swo_pkg::QUO_W) / 64'(s.smaller);
                    if (quotient > 64'(swo_pkg::RATIO_ONE))
                        quotient = 64'(swo_pkg::RATIO_ONE);
                    s.ratio = quotient[swo_pkg::RATIO_W-1:0];
                end
                stored_count  = 0;
                merge_pos     = 0;
                second_taken  = 0;
                sum_first     = '0;
                sum_second    = '0;
                shared_weight = '0;
            end
        end
    endtask

    task automatic send_transaction(input stim_row_t t);
        int             gap;
        bit             produced;
        overlap_score_t predicted;
        gap = (!no_idle && $urandom_range(99) < 35) ? $urandom_range(1, 3) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        list_select <= t.sel;
        term_hash   <= t.hash;
        term_weight <= t.weight;
        no_term     <= t.nt;
        list_end    <= t.le;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        accepted++;
        score_transaction(t, produced, predicted);
        if (produced)
            pending_scores.insert(pending_scores.size(), t.typed ? t.score : predicted);
    endtask

    task automatic run_random_pair();
        logic [swo_pkg::HASH_W-1:0] a_keys[$];
        logic [swo_pkg::HASH_W-1:0] b_keys[$];
        logic [swo_pkg::HASH_W-1:0] key;
        logic [swo_pkg::HASH_W-1:0] swap_key;
        stim_row_t           stream[$];
        int                  len_a;
        int                  flavor;
        int                  split;
        int                  i;
        int                  j;
        int                  roll;
        bit                  long_pair;
        bit                  end_on_term;
        bit                  noisy;
        long_pair   = ($urandom_range(99) < 7);
        flavor      = $urandom_range(99);
        noisy       = (flavor >= 90);
        len_a       = long_pair ? $urandom_range(56, 72) : $urandom_range(0, 10);
        key         = {$urandom, $urandom};
        if (long_pair || $urandom_range(1))
            key = key >> $urandom_range(8, 63);
        for (i = 0; i < len_a; i++)
        begin
            a_keys.insert(a_keys.size(), key);
            if ($urandom_range(9) == 0)
                key = key + 64'({$urandom_range(1, 255), 24'h0});
            else
                key = key + 64'($urandom_range(2, 40));
        end
        if (len_a > 0 && a_keys[0] != '0 && $urandom_range(3) == 0)
            b_keys.insert(b_keys.size(), a_keys[0] - 64'd1);
        for (i = 0; i < len_a; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 55)
                b_keys.insert(b_keys.size(), a_keys[i]);
            else if (roll < 75)
                b_keys.insert(b_keys.size(), a_keys[i] + 64'd1);
        end
        if (len_a == 0)
            repeat ($urandom_range(0, 8)) b_keys.insert(b_keys.size(), {$urandom, $urandom});
        if (long_pair && $urandom_range(1))
            while (b_keys.size() < 70)
                b_keys.insert(b_keys.size(),
                    (b_keys.size() == 0) ? '0 : b_keys[$] + 64'd3);
        if (flavor >= 80 && flavor < 85 && b_keys.size() > 1)
        begin
            i                  = $urandom_range(0, b_keys.size() - 1);
            j                  = $urandom_range(0, b_keys.size() - 1);
            swap_key           = b_keys[i];
            b_keys[i]          = b_keys[j];
            b_keys[j]          = swap_key;
        end
        split = (flavor >= 85 && flavor < 90 && len_a > 1) ?
                $urandom_range(0, len_a - 1) : len_a;
        for (i = 0; i < split; i++)
        begin
            stream.insert(stream.size(), make_row(SEL_FIRST, a_keys[i], pick_weight(),
                1'b0, noisy ? ($urandom_range(1) != 0) : (i == len_a - 1)));
            if (noisy && $urandom_range(4) == 0)
                stream.insert(stream.size(), make_row(SEL_FIRST, {$urandom, $urandom},
                    pick_weight(), 1'b1, 1'b0));
        end
        if (len_a == 0 && $urandom_range(1))
            stream.insert(stream.size(), make_row(SEL_FIRST, {$urandom, $urandom},
                pick_weight(), 1'b1, 1'b1));
        end_on_term = (b_keys.size() > 0) && ($urandom_range(4) != 0);
        for (i = 0; i < b_keys.size(); i++)
        begin
            stream.insert(stream.size(), make_row(SEL_SECOND, b_keys[i], pick_weight(),
                1'b0, end_on_term && (i == b_keys.size() - 1)));
            if (i == 0)
                for (j = split; j < len_a; j++)
                    stream.insert(stream.size(), make_row(SEL_FIRST, a_keys[j],
                        pick_weight(), 1'b0, 1'b0));
            if (noisy && $urandom_range(4) == 0)
                stream.insert(stream.size(), make_row(SEL_SECOND, {$urandom, $urandom},
                    pick_weight(), 1'b1, 1'b0));
        end
        if (b_keys.size() == 0)
            for (j = split; j < len_a; j++)
                stream.insert(stream.size(), make_row(SEL_FIRST, a_keys[j],
                    pick_weight(), 1'b0, 1'b0));
        if (!end_on_term)
            stream.insert(stream.size(), make_row(SEL_SECOND, {$urandom, $urandom},
                pick_weight(), 1'b1, 1'b1));
        foreach (stream[k])
        begin
            no_idle = (random_terms >= 250 && random_terms < 420);
            if (random_terms >= 550)
                hold_request = 1'b1;
            send_transaction(stream[k]);
            if (!stream[k].nt || stream[k].le)
                random_terms++;
        end
    endtask

    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (no_idle)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 35);
        end
    end

    always @(posedge clk)
    begin
        overlap_score_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (pending_scores.size() == 0)
            begin
                $error("result transaction with no expected score pending");
                failures++;
            end
            else
            begin
                want = pending_scores.pop_front();
                scores_seen++;
                if (want.empty)
                    empty_scores++;
                if (overlap_ratio !== want.ratio)
                begin
                    $error("overlap_ratio: expected %0d, actual %0d", want.ratio,
                        overlap_ratio);
                    failures++;
                end
                if (intersection_weight !== want.shared)
                begin
                    $error("intersection_weight: expected %0d, actual %0d",
                        want.shared, intersection_weight);
                    failures++;
                end
                if (smaller_sum !== want.smaller)
                begin
                    $error("smaller_sum: expected %0d, actual %0d", want.smaller,
                        smaller_sum);
                    failures++;
                end
                if (empty_signature !== want.empty)
                begin
                    $error("empty_signature: expected %0d, actual %0d", want.empty,
                        empty_signature);
                    failures++;
                end
            end
        end
    end

    initial
    begin
        stored_count  = 0;
        merge_pos     = 0;
        second_taken  = 0;
        sum_first     = '0;
        sum_second    = '0;
        shared_weight = '0;

        directed_rows = {
            with_score(make_row(SEL_SECOND, '0, '0, 1'b1, 1'b1), '0, '0, '0, 1'b1),
            make_row(SEL_FIRST, '0, '1, 1'b0, 1'b0),
            with_score(make_row(SEL_SECOND, '0, '1, 1'b0, 1'b1),
                swo_pkg::RATIO_ONE, 30'h0FF_FFFF, 30'h0FF_FFFF, 1'b0),
            make_row(SEL_FIRST, '1, 24'd1, 1'b0, 1'b1),
            with_score(make_row(SEL_SECOND, '1, '1, 1'b0, 1'b1),
                swo_pkg::RATIO_ONE, 30'd1, 30'd1, 1'b0),
            make_row(SEL_FIRST, 64'd5, 24'h01_0000, 1'b0, 1'b0),
            with_score(make_row(SEL_SECOND, '1, '1, 1'b1, 1'b1), '0, '0, '0, 1'b1),
            make_row(SEL_FIRST, 64'd10, '0, 1'b0, 1'b0),
            with_score(make_row(SEL_SECOND, 64'd10, 24'h02_0000, 1'b0, 1'b1),
                '0, '0, '0, 1'b1),
            make_row(SEL_FIRST, 64'd1, 24'h03_0000, 1'b0, 1'b0),
            make_row(SEL_FIRST, 64'd2, 24'h01_0000, 1'b0, 1'b0),
            with_score(make_row(SEL_SECOND, 64'd2, 24'h03_0000, 1'b0, 1'b1),
                17'd21845, 30'h001_0000, 30'h003_0000, 1'b0),
            make_row(SEL_FIRST, 64'd20, 24'h100, 1'b0, 1'b1),
            make_row(SEL_SECOND, 64'd10, 24'h100, 1'b0, 1'b0),
            make_row(SEL_FIRST, 64'd30, 24'h100, 1'b0, 1'b0),
            make_row(SEL_SECOND, 64'd30, 24'h200, 1'b0, 1'b1),
            make_row(SEL_FIRST, 64'd100, 24'h1000, 1'b0, 1'b0),
            make_row(SEL_FIRST, '1, '1, 1'b1, 1'b0),
            make_row(SEL_FIRST, 64'd200, 24'h1000, 1'b0, 1'b0),
            make_row(SEL_FIRST, 64'd300, 24'h1000, 1'b0, 1'b1),
            make_row(SEL_SECOND, 64'd300, 24'h1000, 1'b0, 1'b0),
            make_row(SEL_SECOND, '1, '1, 1'b1, 1'b0),
            make_row(SEL_SECOND, 64'd100, 24'h1000, 1'b0, 1'b1)
        };

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[r])
            send_transaction(directed_rows[r]);
        while (random_terms < TARGET_TERMS)
            run_random_pair();
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d input transactions (%0d from the directed table)",
            accepted, directed_rows.size());
        $display("and %0d scores, %0d of them empty-signature, %0d terms past capacity",
            scores_seen, empty_scores, dropped_terms);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
